// File: rtl/core/mex_pkg.sv
// Shared types, constants and the microcode table of the mouse report encoder.
package mex_pkg;

	localparam int unsigned PC_W       = 5;
	localparam int unsigned NUM_DIGITS = 10;
	localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
	localparam int unsigned BIN_W      = 32;
	localparam int unsigned CNT_W      = 5;
	localparam int unsigned PTR_W      = 4;

	localparam logic [15:0] OP_KEY          = 16'h0001;
	localparam logic [15:0] OP_REL          = 16'h0002;
	localparam logic [15:0] AXIS_X          = 16'h0000;
	localparam logic [15:0] AXIS_Y          = 16'h0001;
	localparam logic [15:0] AXIS_WHEEL      = 16'h0008;
	localparam logic [15:0] CODE_LEFT_KEY   = 16'h0110;
	localparam logic [15:0] CODE_RIGHT_KEY  = 16'h0111;
	localparam logic [15:0] CODE_MIDDLE_KEY = 16'h0112;

	localparam logic [6:0] WHEEL_UP_BTN   = 7'd64;
	localparam logic [6:0] WHEEL_DOWN_BTN = 7'd65;
	localparam logic [7:0] X10_OFFSET     = 8'd32;

	localparam logic [7:0] CH_ESC      = 8'h1B;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_LT       = 8'h3C;
	localparam logic [7:0] CH_UPPER_M  = 8'h4D;
	localparam logic [7:0] CH_LOWER_M  = 8'h6D;
	localparam logic [7:0] CH_SEMI     = 8'h3B;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;

	localparam logic [0:0] CFG_TRACKING = 1'b0;
	localparam logic [0:0] CFG_SGR      = 1'b1;

	localparam logic [PC_W-1:0] STEP_IDLE = 5'd0;
	localparam logic [PC_W-1:0] STEP_SGR  = 5'd8;
	localparam logic [PC_W-1:0] STEP_LAST = 5'd22;

	typedef enum logic [2:0] {
		UOP_ACCEPT,
		UOP_BRANCH,
		UOP_EMIT,
		UOP_LOAD,
		UOP_CONVERT,
		UOP_DIGITS
	} uop_t;

	typedef enum logic [3:0] {
		SEL_ESC,
		SEL_LBRACKET,
		SEL_LT,
		SEL_UPPER_M,
		SEL_SEMI,
		SEL_FINAL,
		SEL_X10_BTN,
		SEL_X10_COL,
		SEL_X10_ROW
	} byte_sel_t;

	typedef enum logic [1:0] {
		NUM_BTN,
		NUM_COL,
		NUM_ROW
	} num_sel_t;

	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_ALWAYS,
		JMP_IF_SGR
	} jmp_t;

	typedef struct packed {
		uop_t            uop;
		byte_sel_t       bsel;
		num_sel_t        nsel;
		jmp_t            jmp;
		logic            last;
		logic [PC_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic done;
		logic sgr;
	} status_t;

	function automatic ctrl_t mk(input uop_t u, input byte_sel_t b, input num_sel_t n,
		input jmp_t j, input logic l, input logic [PC_W-1:0] t);
		ctrl_t w;
		w.uop    = u;
		w.bsel   = b;
		w.nsel   = n;
		w.jmp    = j;
		w.last   = l;
		w.target = t;
		return w;
	endfunction

	// Step 0 waits for an event, step 1 picks the report format, steps 2 to 7 send an X10
	// report and steps 8 to 22 an SGR report with three decimal fields.
	function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
		ctrl_t w;
		w = mk(UOP_BRANCH, SEL_ESC, NUM_BTN, JMP_ALWAYS, 1'b0, STEP_IDLE);
		unique case (pc)
			5'd0:  w = mk(UOP_ACCEPT,  SEL_ESC,      NUM_BTN, JMP_NEXT,   1'b0, STEP_IDLE);
			5'd1:  w = mk(UOP_BRANCH,  SEL_ESC,      NUM_BTN, JMP_IF_SGR, 1'b0, STEP_SGR);
			5'd2:  w = mk(UOP_EMIT,    SEL_ESC,      NUM_BTN, JMP_NEXT,   1'b0, STEP_IDLE);
			5'd3:  w = mk(UOP_EMIT,    SEL_LBRACKET, NUM_BTN, JMP_NEXT,   1'b0, STEP_IDLE);
			5'd4:  w = mk(UOP_EMIT,    SEL_UPPER_M,  NUM_BTN, JMP_NEXT,   1'b0, STEP_IDLE);
			5'd5:  w = mk(UOP_EMIT,    SEL_X10_BTN,  NUM_BTN, JMP_NEXT,   1'b0, STEP_IDLE);
			5'd6:  w = mk(UOP_EMIT,    SEL_X10_COL,  NUM_BTN, JMP_NEXT,   1'b0, STEP_IDLE);
			5'd7:  w = mk(UOP_EMIT,    SEL_X10_ROW,  NUM_BTN, JMP_ALWAYS, 1'b1, STEP_IDLE);
			5'd8:  w = mk(UOP_EMIT,    SEL_ESC,      NUM_BTN, JMP_NEXT,   1'b0, STEP_IDLE);
			5'd9:  w = mk(UOP_EMIT,    SEL_LBRACKET, NUM_BTN, JMP_NEXT,   1'b0, STEP_IDLE);
			5'd10: w = mk(UOP_EMIT,    SEL_LT,       NUM_BTN, JMP_NEXT,   1'b0, STEP_IDLE);
			5'd11: w = mk(UOP_LOAD,    SEL_ESC,      NUM_BTN, JMP_NEXT,   1'b0, STEP_IDLE);
			5'd12: w = mk(UOP_CONVERT, SEL_ESC,      NUM_BTN, JMP_NEXT,   1'b0, STEP_IDLE);
			5'd13: w = mk(UOP_DIGITS,  SEL_ESC,      NUM_BTN, JMP_NEXT,   1'b0, STEP_IDLE);
			5'd14: w = mk(UOP_EMIT,    SEL_SEMI,     NUM_BTN, JMP_NEXT,   1'b0, STEP_IDLE);
			5'd15: w = mk(UOP_LOAD,    SEL_ESC,      NUM_COL, JMP_NEXT,   1'b0, STEP_IDLE);
			5'd16: w = mk(UOP_CONVERT, SEL_ESC,      NUM_COL, JMP_NEXT,   1'b0, STEP_IDLE);
			5'd17: w = mk(UOP_DIGITS,  SEL_ESC,      NUM_COL, JMP_NEXT,   1'b0, STEP_IDLE);
			5'd18: w = mk(UOP_EMIT,    SEL_SEMI,     NUM_COL, JMP_NEXT,   1'b0, STEP_IDLE);
			5'd19: w = mk(UOP_LOAD,    SEL_ESC,      NUM_ROW, JMP_NEXT,   1'b0, STEP_IDLE);
			5'd20: w = mk(UOP_CONVERT, SEL_ESC,      NUM_ROW, JMP_NEXT,   1'b0, STEP_IDLE);
			5'd21: w = mk(UOP_DIGITS,  SEL_ESC,      NUM_ROW, JMP_NEXT,   1'b0, STEP_IDLE);
			5'd22: w = mk(UOP_EMIT,    SEL_FINAL,    NUM_ROW, JMP_ALWAYS, 1'b1, STEP_IDLE);
			default: w = mk(UOP_BRANCH, SEL_ESC,     NUM_BTN, JMP_ALWAYS, 1'b0, STEP_IDLE);
		endcase
		return w;
	endfunction

endpackage

// File: rtl/core/mex_sequencer.sv
// Microcode step counter with conditional jumps.
module mex_sequencer import mex_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output ctrl_t   ctrl
);

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_nxt;

	assign ctrl = ucode_rom(pc_q);

	always_comb begin
		pc_nxt = pc_q;
		if (status.done) begin
			unique case (ctrl.jmp)
				JMP_NEXT:   pc_nxt = pc_q + 1'b1;
				JMP_ALWAYS: pc_nxt = ctrl.target;
				JMP_IF_SGR: pc_nxt = status.sgr ? ctrl.target : pc_q + 1'b1;
				default:    pc_nxt = STEP_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else begin
			pc_q <= pc_nxt;
		end
	end

	// The program never runs past its final step.
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n) pc_q <= STEP_LAST)
		else $error("step counter outside the program");

	// A conversion step repeats until the converter reports completion.
	a_convert_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.uop == UOP_CONVERT && !status.done) |=> ctrl.uop == UOP_CONVERT)
		else $error("conversion left early");

	// The format branch follows the selected report format.
	a_branch: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.uop == UOP_BRANCH && ctrl.jmp == JMP_IF_SGR)
		|=> ((pc_q == STEP_SGR) == $past(status.sgr)))
		else $error("format branch went the wrong way");

endmodule

// File: rtl/core/mex_datapath.sv
// Event decode, pointer state, binary to decimal converter and output register.
module mex_datapath import mex_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  ctrl_t              ctrl,
	output status_t            status,
	input  logic               tracking_en,
	input  logic               sgr_mode,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        op,
	input  logic [15:0]        event_code,
	input  logic signed [31:0] event_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               last_byte
);

	logic [31:0]      pos_x_q, pos_y_q;
	logic [2:0]       mask_q;
	logic [6:0]       btn_q;
	logic             press_q;
	logic [BIN_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0] ptr_q;
	logic             started_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             last_q;

	logic             accept, report, upd_x, upd_y, upd_mask, key_hit, wheel_up, press_nxt;
	logic [1:0]       idx;
	logic [2:0]       mask_nxt;
	logic [6:0]       btn_nxt;
	logic [31:0]      value_u;
	logic [31:0]      col, row;
	logic [BIN_W-1:0] num_val, bin_nxt;
	logic [BCD_W-1:0] bcd_adj, bcd_nxt;
	logic [3:0]       cur_digit;
	logic             skip, can_load, load;
	logic [7:0]       emit_byte, load_byte;

	function automatic logic [31:0] clamp_plus_one(input logic [31:0] p);
		return p[31] ? 32'd1 : p + 32'd1;
	endfunction

	assign value_u  = $unsigned(event_value);
	assign in_ready = (ctrl.uop == UOP_ACCEPT);
	assign accept   = in_valid && in_ready;

	always_comb begin
		idx     = 2'd0;
		key_hit = 1'b0;
		unique case (event_code)
			CODE_LEFT_KEY:   begin idx = 2'd0; key_hit = 1'b1; end
			CODE_RIGHT_KEY:  begin idx = 2'd1; key_hit = 1'b1; end
			CODE_MIDDLE_KEY: begin idx = 2'd2; key_hit = 1'b1; end
			default:    ;
		endcase
		mask_nxt = (value_u != 32'd0) ? (mask_q | (3'b001 << idx)) : (mask_q & ~(3'b001 << idx));
		wheel_up = !value_u[31] && (value_u != 32'd0);
		report   = 1'b0;
		upd_x    = 1'b0;
		upd_y    = 1'b0;
		upd_mask = 1'b0;
		btn_nxt  = {5'd0, idx};
		press_nxt = 1'b1;
		if (tracking_en) begin
			if (op == OP_REL) begin
				upd_x = (event_code == AXIS_X);
				upd_y = (event_code == AXIS_Y);
				if (event_code == AXIS_WHEEL && sgr_mode) begin
					report  = 1'b1;
					btn_nxt = wheel_up ? WHEEL_UP_BTN : WHEEL_DOWN_BTN;
				end
			end else if (op == OP_KEY && key_hit) begin
				upd_mask  = 1'b1;
				report    = 1'b1;
				press_nxt = (value_u != 32'd0);
				btn_nxt   = sgr_mode ? ({5'd0, idx} + {4'd0, mask_nxt}) : {5'd0, idx};
			end
		end
	end

	assign col = clamp_plus_one(pos_x_q);
	assign row = clamp_plus_one(pos_y_q);

	always_comb begin
		unique case (ctrl.nsel)
			NUM_BTN: num_val = {25'd0, btn_q};
			NUM_COL: num_val = col;
			NUM_ROW: num_val = row;
			default: num_val = '0;
		endcase
	end

	// One shift-and-add-3 step: correct each decimal digit, then shift in the next bit.
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
			                                              : bcd_q[4*i +: 4];
		end
		bcd_nxt = {bcd_adj[BCD_W-2:0], bin_q[BIN_W-1]};
		bin_nxt = {bin_q[BIN_W-2:0], 1'b0};
	end

	assign cur_digit = bcd_q[{ptr_q, 2'b00} +: 4];
	assign skip      = (cur_digit == 4'd0) && !started_q && (ptr_q != '0);
	assign can_load  = !out_valid_q || out_ready;

	always_comb begin
		unique case (ctrl.bsel)
			SEL_ESC:      emit_byte = CH_ESC;
			SEL_LBRACKET: emit_byte = CH_LBRACKET;
			SEL_LT:       emit_byte = CH_LT;
			SEL_UPPER_M:  emit_byte = CH_UPPER_M;
			SEL_SEMI:     emit_byte = CH_SEMI;
			SEL_FINAL:    emit_byte = press_q ? CH_UPPER_M : CH_LOWER_M;
			SEL_X10_BTN:  emit_byte = {1'b0, btn_q} + X10_OFFSET;
			SEL_X10_COL:  emit_byte = col[7:0] + X10_OFFSET;
			SEL_X10_ROW:  emit_byte = row[7:0] + X10_OFFSET;
			default:      emit_byte = CH_ESC;
		endcase
	end

	assign load      = can_load && ((ctrl.uop == UOP_EMIT) || (ctrl.uop == UOP_DIGITS && !skip));
	assign load_byte = (ctrl.uop == UOP_DIGITS) ? (CH_ZERO + {4'd0, cur_digit}) : emit_byte;

	always_comb begin
		status.sgr = sgr_mode;
		unique case (ctrl.uop)
			UOP_ACCEPT:  status.done = accept && report;
			UOP_BRANCH:  status.done = 1'b1;
			UOP_EMIT:    status.done = load;
			UOP_LOAD:    status.done = 1'b1;
			UOP_CONVERT: status.done = (cnt_q == '1);
			UOP_DIGITS:  status.done = load && (ptr_q == '0);
			default:     status.done = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			mask_q  <= '0;
		end else if (accept) begin
			if (upd_x) begin
				pos_x_q <= pos_x_q + value_u;
			end
			if (upd_y) begin
				pos_y_q <= pos_y_q + value_u;
			end
			if (upd_mask) begin
				mask_q <= mask_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && report) begin
			btn_q   <= btn_nxt;
			press_q <= press_nxt;
		end
		if (ctrl.uop == UOP_LOAD) begin
			bin_q <= num_val;
			bcd_q <= '0;
		end else if (ctrl.uop == UOP_CONVERT) begin
			bin_q <= bin_nxt;
			bcd_q <= bcd_nxt;
		end
		if (load) begin
			out_byte_q <= load_byte;
			last_q     <= ctrl.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ptr_q       <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.uop == UOP_LOAD) begin
				cnt_q     <= '0;
				ptr_q     <= PTR_W'(NUM_DIGITS - 1);
				started_q <= 1'b0;
			end else if (ctrl.uop == UOP_CONVERT) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (ctrl.uop == UOP_DIGITS) begin
				if (skip) begin
					ptr_q <= ptr_q - 1'b1;
				end else if (load) begin
					started_q <= 1'b1;
					ptr_q     <= ptr_q - 1'b1;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = last_q;

	// Every bit has been shifted into the decimal register before digits go out.
	a_bin_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.uop == UOP_DIGITS) |-> (bin_q == '0))
		else $error("digits sent before conversion finished");

	// A digit step only ever loads an ASCII decimal digit.
	a_digit_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		(load && ctrl.uop == UOP_DIGITS) |=> (out_byte_q >= CH_ZERO && out_byte_q <= CH_NINE))
		else $error("decimal digit out of range");

	// Once the final byte of a report is loaded the block takes the next event.
	a_last_then_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(load && ctrl.last) |=> in_ready)
		else $error("no return to idle after the final byte");

endmodule

// File: rtl/core/mouse_event_to_xterm_escape_unit.sv
// Mouse event to xterm report encoder: top level with the configuration registers.
//
// Each accepted word is one input event. Relative X and Y events add their value to two
// wrapping 32-bit pointer positions and produce nothing; button events update a three-bit
// mask and produce a report, and a wheel event produces a report in SGR format only. An
// event that produces no report, and every event while tracking is off, is taken at once
// and the block stays ready. A report leaves one byte per output word, with last_byte
// marking its final byte. After the format branch an X10 report sends six bytes: ESC, [,
// M, then the button, column and row bytes, each offset by 32. An SGR report sends ESC,
// [ and <, three decimal fields split by two separators, and a final M, or m for a button
// release. Each field is loaded, its 32 bits pass through the binary to decimal converter
// one bit per cycle, and its ten digit positions are stepped through, a leading zero being
// dropped. The output register lets the next event be accepted while the final byte of
// the previous report still waits, and any stall on the output side holds the report.
// Configuration should only be written while no report is in progress.
module mouse_event_to_xterm_escape_unit import mex_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic [0:0]         cfg_index,
	input  logic [0:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        op,
	input  logic [15:0]        event_code,
	input  logic signed [31:0] event_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               last_byte
);

	logic    tracking_q;
	logic    sgr_q;
	ctrl_t   ctrl;
	status_t status;

	// Configuration registers: tracking on or off, and the report format.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_q <= 1'b0;
			sgr_q      <= 1'b0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CFG_TRACKING: tracking_q <= cfg_data[0];
				CFG_SGR:      sgr_q      <= cfg_data[0];
				default:      ;
			endcase
		end
	end

	// The sequencer steps through the microcode; the datapath carries out each control word.
	mex_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	mex_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.status      (status),
		.tracking_en (tracking_q),
		.sgr_mode    (sgr_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.event_code  (event_code),
		.event_value (event_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last_byte   (last_byte)
	);

endmodule
